/* hw/rtl/atoi_pkg.sv */
`default_nettype none

package atoi_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned RadixW = 5;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CharsW = 16;

  localparam logic [RadixW-1:0] RadixAuto = 5'd0;
  localparam logic [RadixW-1:0] RadixOct  = 5'd8;
  localparam logic [RadixW-1:0] RadixDec  = 5'd10;
  localparam logic [RadixW-1:0] RadixHex  = 5'd16;
  localparam logic [RadixW-1:0] DigitNone = 5'd16;

  localparam logic [CharW-1:0] CaseBit = 8'h20;
  localparam logic [CharW-1:0] ChrZero = 8'h30;
  localparam logic [CharW-1:0] ChrNine = 8'h39;
  localparam logic [CharW-1:0] ChrLowA = 8'h61;
  localparam logic [CharW-1:0] ChrLowF = 8'h66;
  localparam logic [CharW-1:0] ChrLowX = 8'h78;

  // controller -> datapath, valid for one accepted transaction
  typedef struct packed {
    logic              load;     // update the string state
    logic              clear;    // start from zero value, count and overflow
    logic              set_two;  // force the count to two (hex prefix)
    logic              bump;     // count one character without a digit
    logic              take;     // accumulate the current digit
    logic              emit;     // capture a result into the output register
    logic [RadixW-1:0] radix;    // radix that applies from this transaction on
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [RadixW-1:0] digit;     // digit value, DigitNone for a non-digit
    logic              is_zero;   // character is '0'
    logic              is_x;      // character is 'x' or 'X'
    logic [RadixW-1:0] radix_in;  // requested radix, clamped to 16
    logic [RadixW-1:0] radix_q;   // radix held for the current string
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/atoi_dp.sv */
`default_nettype none

module atoi_dp #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic [atoi_pkg::CharW-1:0]    char_i,
  input  wire logic [atoi_pkg::RadixW-1:0]   radix_i,
  input  wire atoi_pkg::cmd_t                cmd_i,
  output atoi_pkg::sts_t                     sts_o,
  output logic      [atoi_pkg::ValueW-1:0]   value_o,
  output logic      [atoi_pkg::CharsW-1:0]   chars_used_o,
  output logic                               overflowed_o,
  output logic      [atoi_pkg::RadixW-1:0]   radix_used_o
);

  localparam int unsigned CntW  = (COUNT_BITS > atoi_pkg::CharsW) ? atoi_pkg::CharsW
                                                                  : COUNT_BITS;
  localparam int unsigned ProdW = atoi_pkg::ValueW + atoi_pkg::RadixW;

  logic [atoi_pkg::ValueW-1:0] acc_q, acc_d, acc_base;
  logic                        ovf_q, ovf_d, ovf_base;
  logic [CntW-1:0]             cnt_q, cnt_d, cnt_base;
  logic [atoi_pkg::RadixW-1:0] radix_q;
  logic [atoi_pkg::CharW-1:0]  lower;
  logic [atoi_pkg::RadixW-1:0] digit;
  logic [ProdW-1:0]            prod, sum;

  // character classification
  always_comb begin
    lower = char_i | atoi_pkg::CaseBit;
    if (char_i >= atoi_pkg::ChrZero && char_i <= atoi_pkg::ChrNine) begin
      digit = atoi_pkg::RadixW'(char_i - atoi_pkg::ChrZero);
    end else if (lower >= atoi_pkg::ChrLowA && lower <= atoi_pkg::ChrLowF) begin
      digit = atoi_pkg::RadixW'(lower - atoi_pkg::ChrLowA + 8'd10);
    end else begin
      digit = atoi_pkg::DigitNone;
    end
  end

  always_comb begin
    sts_o.digit    = digit;
    sts_o.is_zero  = (char_i == atoi_pkg::ChrZero);
    sts_o.is_x     = (lower == atoi_pkg::ChrLowX);
    sts_o.radix_in = (radix_i > atoi_pkg::RadixHex) ? atoi_pkg::RadixHex : radix_i;
    sts_o.radix_q  = radix_q;
  end

  // accumulate: value * radix + digit, carry-out above 64 bits marks overflow
  always_comb begin
    acc_base = cmd_i.clear ? '0 : acc_q;
    ovf_base = cmd_i.clear ? 1'b0 : ovf_q;
    if (cmd_i.clear) begin
      cnt_base = '0;
    end else if (cmd_i.set_two) begin
      cnt_base = CntW'(2);
    end else begin
      cnt_base = cnt_q;
    end

    prod = ProdW'(acc_base) * ProdW'(cmd_i.radix);
    sum  = prod + ProdW'(digit);

    if (cmd_i.take) begin
      acc_d = sum[atoi_pkg::ValueW-1:0];
      ovf_d = ovf_base | (|sum[ProdW-1:atoi_pkg::ValueW]);
    end else begin
      acc_d = acc_base;
      ovf_d = ovf_base;
    end

    // saturate the character count
    if ((cmd_i.take || cmd_i.bump) && (cnt_base != '1)) begin
      cnt_d = cnt_base + CntW'(1);
    end else begin
      cnt_d = cnt_base;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
      radix_q <= cmd_i.radix;
    end
    if (cmd_i.emit) begin
      value_o      <= acc_d;
      chars_used_o <= atoi_pkg::CharsW'(cnt_d);
      overflowed_o <= ovf_d;
      radix_used_o <= cmd_i.radix;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/atoi_ctrl.sv */
`default_nettype none

module atoi_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic           start_i,
  input  wire logic           final_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire atoi_pkg::sts_t sts_i,
  output atoi_pkg::cmd_t      cmd_o
);

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhDigits = 2'd1;
  localparam logic [1:0] PhZero   = 2'd2;
  localparam logic [1:0] PhZeroX  = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic       out_valid_q, out_valid_d;
  logic       fire;
  logic [atoi_pkg::RadixW-1:0] rad;
  logic [atoi_pkg::RadixW-1:0] rad_oct;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign fire        = in_valid_i && in_ready_o;

  // radix held so far, with automatic mode falling back to octal
  assign rad_oct = (sts_i.radix_q == atoi_pkg::RadixAuto) ? atoi_pkg::RadixOct
                                                          : sts_i.radix_q;

  always_comb begin
    cmd_o   = '0;
    phase_d = phase_q;
    rad     = sts_i.radix_q;

    if (fire) begin
      if (start_i) begin
        cmd_o.load  = 1'b1;
        cmd_o.clear = 1'b1;
        if ((sts_i.radix_in == atoi_pkg::RadixAuto || sts_i.radix_in == atoi_pkg::RadixHex)
            && sts_i.is_zero) begin
          // leading zero: radix still open, count the zero
          cmd_o.bump  = 1'b1;
          cmd_o.emit  = final_i;
          cmd_o.radix = (final_i && sts_i.radix_in == atoi_pkg::RadixAuto)
                        ? atoi_pkg::RadixOct : sts_i.radix_in;
          phase_d     = PhZero;
        end else begin
          rad = (sts_i.radix_in == atoi_pkg::RadixAuto) ? atoi_pkg::RadixDec
                                                        : sts_i.radix_in;
          cmd_o.radix = rad;
          cmd_o.take  = (rad != '0) && (sts_i.digit < rad);
          cmd_o.emit  = !cmd_o.take || final_i;
          phase_d     = PhDigits;
        end
      end else begin
        unique case (phase_q)
          PhIdle: begin
            phase_d = PhIdle;
          end
          PhZero: begin
            cmd_o.load = 1'b1;
            if (sts_i.is_x) begin
              if (final_i) begin
                // prefix ends the string: the zero alone is the number
                cmd_o.radix   = rad_oct;
                cmd_o.set_two = (sts_i.radix_q != atoi_pkg::RadixAuto);
                cmd_o.emit    = 1'b1;
              end else begin
                cmd_o.radix = sts_i.radix_q;
              end
              phase_d = PhZeroX;
            end else begin
              cmd_o.radix = rad_oct;
              cmd_o.take  = (sts_i.digit < rad_oct);
              cmd_o.emit  = !cmd_o.take || final_i;
              phase_d     = PhDigits;
            end
          end
          PhZeroX: begin
            cmd_o.load = 1'b1;
            if (sts_i.digit != atoi_pkg::DigitNone) begin
              cmd_o.radix   = atoi_pkg::RadixHex;
              cmd_o.set_two = 1'b1;
              cmd_o.take    = 1'b1;
              cmd_o.emit    = final_i;
              phase_d       = PhDigits;
            end else begin
              cmd_o.radix   = rad_oct;
              cmd_o.set_two = (sts_i.radix_q != atoi_pkg::RadixAuto);
              cmd_o.emit    = 1'b1;
            end
          end
          PhDigits: begin
            cmd_o.load  = 1'b1;
            cmd_o.radix = sts_i.radix_q;
            cmd_o.take  = (sts_i.radix_q != '0) && (sts_i.digit < sts_i.radix_q);
            cmd_o.emit  = !cmd_o.take || final_i;
          end
          default: begin
            phase_d = PhIdle;
          end
        endcase
      end
      if (cmd_o.emit) begin
        phase_d = PhIdle;
      end
    end
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ascii_to_unsigned_integer.sv */
// Streaming unsigned integer parser, strtoull style.
// Input stream: one character per transaction. tuser marks the first character
// of a string, whose tdata also carries the requested radix (0 = automatic,
// above 16 taken as 16). tlast marks the last character; the end of the
// string then acts as a terminator.
// Output stream: one transaction per string, at the first non-digit or after
// the tlast character: value modulo 2^64, characters consumed (prefix
// included, terminator not), the radix applied, and the overflow flag in tuser.
// Throughput: one character per cycle while s_axis_tready is high. The accumulate
// step (64 x 5 bit multiply, digit add, carry-out check) finishes within the
// accepting cycle. The result shows on m_axis_tvalid in the cycle after the
// terminating transaction is accepted.
// Stall: the result waits in the output register; s_axis_tready drops only
// while that register is full and m_axis_tready is low, so no character is lost.
// Reset: the parser goes idle, waiting for a start character; characters
// without start while idle are dropped. A start in mid-string discards it.
`default_nettype none

module ascii_to_unsigned_integer #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // character [7:0], radix [12:8], zero [15:13]
  input  wire logic        s_axis_tuser,   // start_req
  input  wire logic        s_axis_tlast,   // final_req
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,   // value [63:0], chars_used [79:64],
                                           // radix_used [84:80], zero [87:85]
  output logic             m_axis_tuser    // overflowed
);

  atoi_pkg::cmd_t cmd;
  atoi_pkg::sts_t sts;

  logic [atoi_pkg::ValueW-1:0] value;
  logic [atoi_pkg::CharsW-1:0] chars_used;
  logic [atoi_pkg::RadixW-1:0] radix_used;

  atoi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .start_i     (s_axis_tuser),
    .final_i     (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  atoi_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .char_i       (s_axis_tdata[7:0]),
    .radix_i      (s_axis_tdata[12:8]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_o      (value),
    .chars_used_o (chars_used),
    .overflowed_o (m_axis_tuser),
    .radix_used_o (radix_used)
  );

  assign m_axis_tdata = {3'b000, radix_used, chars_used, value};

`ifndef SYNTHESIS
  // input stalls only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a pending result");

  // automatic mode always resolves to a real radix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (radix_used != 5'd0) && (radix_used <= 5'd16))
    else $error("result radix out of range");

  // no character consumed means no digit was accumulated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (chars_used == 16'd0)) |-> ((value == 64'd0) && !m_axis_tuser))
    else $error("value without consumed characters");

  // a result is captured only from an accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !$past(m_axis_tvalid)) |->
      $past(s_axis_tvalid && s_axis_tready))
    else $error("result appeared without an input transaction");
`endif

endmodule

`default_nettype wire
